FILE: rtl/alu32f_pkg.sv
// alu32f_pkg: operation codes and payload types for the 32-bit alu with flags
// no dependencies; imported by alu32f_exec and alu32_with_flags
package alu32f_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned OpWidth    = 5;
   localparam int unsigned ShamtWidth = 5;

   localparam logic [OpWidth-1:0] OP_ADD    = 5'd0;
   localparam logic [OpWidth-1:0] OP_SUB    = 5'd1;
   localparam logic [OpWidth-1:0] OP_AND    = 5'd2;
   localparam logic [OpWidth-1:0] OP_OR     = 5'd3;
   localparam logic [OpWidth-1:0] OP_XOR    = 5'd4;
   localparam logic [OpWidth-1:0] OP_SLL    = 5'd5;
   localparam logic [OpWidth-1:0] OP_SRL    = 5'd6;
   localparam logic [OpWidth-1:0] OP_SRA    = 5'd7;
   localparam logic [OpWidth-1:0] OP_SLT    = 5'd8;
   localparam logic [OpWidth-1:0] OP_SLTU   = 5'd9;
   localparam logic [OpWidth-1:0] OP_PASS_A = 5'd10;
   localparam logic [OpWidth-1:0] OP_PASS_B = 5'd11;
   localparam logic [OpWidth-1:0] OP_ZERO   = 5'd12;

   typedef struct packed {
      logic [WordWidth-1:0] operand_a;
      logic [WordWidth-1:0] operand_b;
      logic [OpWidth-1:0]   req_type;
   } req_payload_type;

   typedef struct packed {
      logic [WordWidth-1:0] result;
      logic                 zero_flag;
      logic                 equal_flag;
      logic                 less_signed;
      logic                 less_unsigned;
      logic                 negative_flag;
      logic                 carry_flag;
      logic                 overflow_flag;
   } rsp_payload_type;

endpackage

FILE: rtl/alu32f_exec.sv
// alu32f_exec: combinational datapath, one operation and its flags
// depends on alu32f_pkg
module alu32f_exec (
   input  alu32f_pkg::req_payload_type req,
   output alu32f_pkg::rsp_payload_type rsp
);
   import alu32f_pkg::*;

   logic [WordWidth-1:0]  a;
   logic [WordWidth-1:0]  b;
   logic [ShamtWidth-1:0] shamt;
   logic [WordWidth:0]    sum;
   logic [WordWidth:0]    diff;
   logic                  add_ovf;
   logic                  sub_ovf;
   logic                  lt_s;
   logic                  lt_u;
   logic                  eq;
   logic                  cmp;
   logic [WordWidth-1:0]  r;

   assign a     = req.operand_a;
   assign b     = req.operand_b;
   assign shamt = b[ShamtWidth-1:0];
   assign sum   = {1'b0, a} + {1'b0, b};
   // diff msb is the no-borrow bit, set when a >= b unsigned
   assign diff  = {1'b0, a} + {1'b0, ~b} + {{WordWidth{1'b0}}, 1'b1};

   assign add_ovf = ~(a[WordWidth-1] ^ b[WordWidth-1])
                    & (a[WordWidth-1] ^ sum[WordWidth-1]);
   assign sub_ovf = (a[WordWidth-1] ^ b[WordWidth-1])
                    & (a[WordWidth-1] ^ diff[WordWidth-1]);
   assign lt_s    = diff[WordWidth-1] ^ sub_ovf;
   assign lt_u    = ~diff[WordWidth];
   assign eq      = (a == b);
   assign cmp     = (req.req_type == OP_SUB) || (req.req_type == OP_SLT)
                    || (req.req_type == OP_SLTU);

   always_comb begin
      unique case (req.req_type)
         OP_ADD:    r = sum[WordWidth-1:0];
         OP_SUB:    r = diff[WordWidth-1:0];
         OP_AND:    r = a & b;
         OP_OR:     r = a | b;
         OP_XOR:    r = a ^ b;
         OP_SLL:    r = a << shamt;
         OP_SRL:    r = a >> shamt;
         OP_SRA:    r = WordWidth'($signed(a) >>> shamt);
         OP_SLT:    r = {{(WordWidth-1){1'b0}}, lt_s};
         OP_SLTU:   r = {{(WordWidth-1){1'b0}}, lt_u};
         OP_PASS_A: r = a;
         OP_PASS_B: r = b;
         OP_ZERO:   r = '0;
         default:   r = '0;
      endcase
   end

   always_comb begin
      rsp.result        = r;
      rsp.zero_flag     = (r == '0);
      rsp.equal_flag    = cmp & eq;
      rsp.less_signed   = cmp & lt_s;
      rsp.less_unsigned = cmp & lt_u;
      rsp.negative_flag = r[WordWidth-1];
      if (req.req_type == OP_ADD) begin
         rsp.carry_flag    = sum[WordWidth];
         rsp.overflow_flag = add_ovf;
      end else if (cmp) begin
         rsp.carry_flag    = diff[WordWidth];
         rsp.overflow_flag = sub_ovf;
      end else begin
         rsp.carry_flag    = 1'b0;
         rsp.overflow_flag = 1'b0;
      end
   end

endmodule

FILE: rtl/alu32_with_flags.sv
// alu32_with_flags: top level, input register, alu datapath and result register
// depends on alu32f_pkg and alu32f_exec
//
//  channel | ports                                  | role
//  --------+----------------------------------------+------------------------
//  req     | req_valid, req_ready, req_payload      | operands and op code in
//  rsp     | rsp_valid, rsp_ready, rsp_payload      | result word and flags out
//
// result valid after both registers; one item per cycle while rsp_ready high
// the input register feeds the datapath, the result register holds the answer
// a stalled result register stalls the input register, which keeps its item
// req_ready stays high while either register can move or is empty
// synchronous reset clears both valid bits only
module alu32_with_flags (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  alu32f_pkg::req_payload_type req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output alu32f_pkg::rsp_payload_type rsp_payload
);
   import alu32f_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;
   rsp_payload_type exec_rsp;
   logic            out_load;
   logic            in_load;

   alu32f_exec u_exec (
      .req (in_data_ff),
      .rsp (exec_rsp)
   );

   assign out_load  = ~out_valid_ff | rsp_ready;
   assign in_load   = ~in_valid_ff | out_load;
   assign req_ready = in_load;

   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_data_ff <= req_payload;
      end
      if (out_load && in_valid_ff) begin
         out_data_ff <= exec_rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule
